// File: rtl/core/rcb_pkg.sv
package rcb_pkg;

   // Channel code width, unsigned fixed point
   localparam int CHANNEL_BITS = 16;
   // Register widths and frame height limit
   localparam int WIDTH_BITS  = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int ROW_BITS    = 12;
   localparam int MAX_HEIGHT  = 4096;
   // Results one request can cause
   localparam int RESULT_SLOTS = 4;

   // Register indexes of the write port
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_out;
      logic [CHANNEL_BITS-1:0] green_out;
      logic [CHANNEL_BITS-1:0] blue_out;
      logic                    last_of_run;
      logic                    frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   // Position of a request within the frame
   typedef struct packed {
      logic r_ge1;
      logic r_ge2;
      logic c_ge1;
      logic c_ge2;
      logic row_end;
      logic last_row;
   } flags_type;

   // Taps presented to the kernel
   typedef struct packed {
      flags_type       flags;
      pixel_type       p;
      pixel_type       mid;
      pixel_type       up;
      pixel_type [4:0] win;
   } taps_type;

   // Up to four results of one request, in output order
   typedef struct packed {
      logic [RESULT_SLOTS-1:0] mask;
      pixel_type [RESULT_SLOTS-1:0] pix;
   } bundle_type;

endpackage

// File: rtl/core/rgb_cross_blur_clamped.sv
// Five-point cross blur of an RGB raster stream (up, down, left and right weigh one, the
// center four, sum over eight truncated), with neighbors past the frame edge clamped to
// the edge. A pixel is taken every clock while the output is not stalled and it causes
// at most one result; a pixel that ends a row causes two, and on the last row of the
// frame up to four, and the single result register hands these out one per clock
// while rsp_ready is high, so the input waits until results beyond the first are out.
// Results come one row and one pixel behind the input (one pixel behind on the last
// row). Each of the two row stores has one write and one registered read port; a store
// entry is used only once written, so no clearing pass runs after reset. Width and
// height must be written through the csr_ port while the stream is idle (unenforced).
module rgb_cross_blur_clamped #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  rcb_pkg::req_payload_type                    req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output rcb_pkg::rsp_payload_type                    rsp_data,
   input  logic                                        csr_we,
   input  logic [0:0]                                  csr_index,
   input  logic [rcb_pkg::HEIGHT_BITS-1:0]             csr_wdata
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int CMPW = ((AW > rcb_pkg::WIDTH_BITS) ? AW : rcb_pkg::WIDTH_BITS) + 1;
   localparam int RB   = rcb_pkg::ROW_BITS;
   localparam int HB   = rcb_pkg::HEIGHT_BITS;

   logic [rcb_pkg::WIDTH_BITS-1:0] width_ff;
   logic [HB-1:0]                  height_ff;
   logic [AW-1:0]                  col_count_ff, col_count_in;
   logic [RB-1:0]                  row_count_ff, row_count_in;

   logic                           s1_valid_ff;
   rcb_pkg::pixel_type             s1_pix_ff;
   rcb_pkg::flags_type             s1_flags_ff;
   logic [AW-1:0]                  s1_addr_ff;
   logic                           bypass_ff;
   rcb_pkg::pixel_type             byp_newer_ff, byp_older_ff;
   rcb_pkg::pixel_type [4:0]       win_ff;

   logic [CMPW-1:0]                wm1;
   logic [HB-1:0]                  hm1;
   logic                           row_end, last_row;
   logic [AW-1:0]                  cur_addr;
   rcb_pkg::flags_type             cur_flags;
   rcb_pkg::pixel_type             cur_pix;
   logic                           accept, s1_adv, q_free;
   rcb_pkg::pixel_type             newer_rd, older_rd, mid, up;
   rcb_pkg::taps_type              taps;
   rcb_pkg::bundle_type            bundle;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rcb_pkg::WIDTH_BITS'(640);
         height_ff <= HB'(480);
      end else if (csr_we) begin
         case (csr_index)
            rcb_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[rcb_pkg::WIDTH_BITS-1:0];
            rcb_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp width and height to their usable range, less one
   always_comb begin
      if (width_ff == '0) begin
         wm1 = '0;
      end else if (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) begin
         wm1 = CMPW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CMPW'(width_ff) - CMPW'(1);
      end
      if (height_ff == '0) begin
         hm1 = '0;
      end else if (height_ff > HB'(rcb_pkg::MAX_HEIGHT)) begin
         hm1 = HB'(rcb_pkg::MAX_HEIGHT - 1);
      end else begin
         hm1 = height_ff - HB'(1);
      end
   end

   assign row_end  = CMPW'(col_count_ff) >= wm1;
   assign last_row = HB'(row_count_ff) >= hm1;
   assign cur_addr = (CMPW'(col_count_ff) < CMPW'(MAX_WIDTH)) ? col_count_ff
                                                              : AW'(MAX_WIDTH - 1);

   assign cur_flags.r_ge1    = row_count_ff >= RB'(1);
   assign cur_flags.r_ge2    = row_count_ff >= RB'(2);
   assign cur_flags.c_ge1    = col_count_ff >= AW'(1);
   assign cur_flags.c_ge2    = CMPW'(col_count_ff) >= CMPW'(2);
   assign cur_flags.row_end  = row_end;
   assign cur_flags.last_row = last_row;

   assign cur_pix.red   = req_data.red_in;
   assign cur_pix.green = req_data.green_in;
   assign cur_pix.blue  = req_data.blue_in;

   // Handshake: stage one moves on when the result register can take its bundle
   assign s1_adv    = s1_valid_ff & q_free;
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign accept    = req_valid & req_ready;

   // Advance column and row position
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (row_end) begin
            col_count_in = '0;
            row_count_in = last_row ? '0 : row_count_ff + RB'(1);
         end else begin
            col_count_in = col_count_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request and forward a store write to the same entry
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= cur_pix;
         s1_flags_ff  <= cur_flags;
         s1_addr_ff   <= cur_addr;
         bypass_ff    <= s1_adv & (s1_addr_ff == cur_addr);
         byp_newer_ff <= s1_pix_ff;
         byp_older_ff <= mid;
      end
   end

   rcb_line_store #(.DEPTH(MAX_WIDTH)) u_newer_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (cur_addr),
      .rd_data (newer_rd)
   );

   rcb_line_store #(.DEPTH(MAX_WIDTH)) u_older_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (mid),
      .rd_en   (accept),
      .rd_addr (cur_addr),
      .rd_data (older_rd)
   );

   // Clamp vertical taps at the top of the frame
   assign mid = s1_flags_ff.r_ge1 ? (bypass_ff ? byp_newer_ff : newer_rd) : s1_pix_ff;
   assign up  = s1_flags_ff.r_ge2 ? (bypass_ff ? byp_older_ff : older_rd) : mid;

   // Shift the window
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff[0] <= up;
         win_ff[1] <= win_ff[2];
         win_ff[2] <= mid;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= s1_pix_ff;
      end
   end

   assign taps.flags = s1_flags_ff;
   assign taps.p     = s1_pix_ff;
   assign taps.mid   = mid;
   assign taps.up    = up;
   assign taps.win   = win_ff;

   rcb_kernel u_kernel (
      .taps   (taps),
      .bundle (bundle)
   );

   rcb_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_adv),
      .bundle    (bundle),
      .free      (q_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Frame end is always the last result of its request
   a_frame_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.last_of_run)
      else $error("frame_done without last_of_run");

   // Bottom-right pixel returns the position to the frame start
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_end && last_row |=> col_count_ff == '0 && row_count_ff == '0)
      else $error("position did not wrap at frame end");

   // A stalled request keeps its pixel in stage one
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_pix_ff))
      else $error("stage one lost a stalled request");
`endif

endmodule

// File: rtl/core/rcb_line_store.sv
module rcb_line_store #(
   parameter int DEPTH = 2048
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  rcb_pkg::pixel_type           wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output rcb_pkg::pixel_type           rd_data
);

   rcb_pkg::pixel_type store_ff [DEPTH];
   rcb_pkg::pixel_type rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rcb_kernel.sv
module rcb_kernel (
   input  rcb_pkg::taps_type   taps,
   output rcb_pkg::bundle_type bundle
);

   localparam int CB = rcb_pkg::CHANNEL_BITS;

   // (u + d + l + r + 4c) / 8, truncated
   function automatic logic [CB-1:0] blur_ch(input logic [CB-1:0] u, input logic [CB-1:0] d,
                                             input logic [CB-1:0] l, input logic [CB-1:0] r,
                                             input logic [CB-1:0] c);
      logic [CB+2:0] s;
      s = {3'b000, u} + {3'b000, d} + {3'b000, l} + {3'b000, r} + {1'b0, c, 2'b00};
      return s[CB+2:3];
   endfunction

   function automatic rcb_pkg::pixel_type blur_px(input rcb_pkg::pixel_type u,
                                                  input rcb_pkg::pixel_type d,
                                                  input rcb_pkg::pixel_type l,
                                                  input rcb_pkg::pixel_type r,
                                                  input rcb_pkg::pixel_type c);
      rcb_pkg::pixel_type o;
      o.red   = blur_ch(u.red,   d.red,   l.red,   r.red,   c.red);
      o.green = blur_ch(u.green, d.green, l.green, r.green, c.green);
      o.blue  = blur_ch(u.blue,  d.blue,  l.blue,  r.blue,  c.blue);
      return o;
   endfunction

   rcb_pkg::flags_type f;
   rcb_pkg::pixel_type lf0, lf1, lf2, lf3;

   assign f = taps.flags;

   // Clamp the left tap at the start of a row
   assign lf0 = f.c_ge2 ? taps.win[1] : taps.win[2];
   assign lf1 = f.c_ge1 ? taps.win[2] : taps.mid;
   assign lf2 = f.c_ge2 ? taps.win[3] : taps.win[4];
   assign lf3 = f.c_ge1 ? taps.win[4] : taps.p;

   // Row above: pixel behind, then row end flush
   assign bundle.pix[0] = blur_px(taps.win[0], taps.win[4], lf0, taps.mid, taps.win[2]);
   assign bundle.pix[1] = blur_px(taps.up, taps.p, lf1, taps.mid, taps.mid);
   // Last row: pixel behind, then frame end flush
   assign bundle.pix[2] = blur_px(taps.win[2], taps.win[4], lf2, taps.p, taps.win[4]);
   assign bundle.pix[3] = blur_px(taps.mid, taps.p, lf3, taps.p, taps.p);

   assign bundle.mask = {f.last_row & f.row_end, f.last_row & f.c_ge1,
                         f.r_ge1 & f.row_end, f.r_ge1 & f.c_ge1};

endmodule

// File: rtl/core/rcb_result_queue.sv
module rcb_result_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  rcb_pkg::bundle_type      bundle,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rcb_pkg::rsp_payload_type rsp_data
);

   localparam int NS = rcb_pkg::RESULT_SLOTS;
   localparam int SW = $clog2(NS);

   logic [NS-1:0]                 mask_ff, mask_in;
   rcb_pkg::pixel_type [NS-1:0]   pix_ff;
   logic [SW-1:0]                 sel;
   logic [NS-1:0]                 remain;
   logic                          pop;

   // Pick the earliest pending slot
   always_comb begin
      sel = '0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SW'(i);
         end
      end
   end

   assign remain    = mask_ff & ~(NS'(1) << sel);
   assign rsp_valid = |mask_ff;
   assign pop       = rsp_valid & rsp_ready;
   assign free      = (mask_ff == '0) | ((remain == '0) & rsp_ready);

   assign rsp_data.red_out     = pix_ff[sel].red;
   assign rsp_data.green_out   = pix_ff[sel].green;
   assign rsp_data.blue_out    = pix_ff[sel].blue;
   assign rsp_data.last_of_run = (remain == '0);
   assign rsp_data.frame_done  = (sel == SW'(NS - 1));

   // Load a new bundle or drop the slot just taken
   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = bundle.mask;
      end else if (pop) begin
         mask_in = remain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= bundle.pix;
      end
   end

endmodule
